// ----- sv/midi_event_to_psg_register_writes_macros.svh -----
// Assertion macros for the MIDI event to sound register write block.
// Used by the checker only; no dependencies.
`ifndef MIDI_EVENT_TO_PSG_REGISTER_WRITES_MACROS_SVH
`define MIDI_EVENT_TO_PSG_REGISTER_WRITES_MACROS_SVH

// check a property on every edge outside reset
`define M2P_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every edge, reset included
`define M2P_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/m2p_pkg.sv -----
// Shared types, codes and lookup tables for the MIDI event to sound register block.
// No dependencies.
package m2p_pkg;

   localparam logic [7:0] NOTE_ON  = 8'h90;
   localparam logic [7:0] NOTE_OFF = 8'h80;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // command codes handed from the front end to the write sequencer
   localparam logic [1:0] OP_PULSE_ON = 2'd0;
   localparam logic [1:0] OP_WAVE_ON  = 2'd1;
   localparam logic [1:0] OP_NOISE_ON = 2'd2;
   localparam logic [1:0] OP_OFF      = 2'd3;

   localparam logic [1:0] VOICE_PULSE1 = 2'd0;
   localparam logic [1:0] VOICE_PULSE2 = 2'd1;
   localparam logic [1:0] VOICE_WAVE   = 2'd2;
   localparam logic [1:0] VOICE_NOISE  = 2'd3;

   localparam logic [7:0] PERIOD_BASE = 8'd36;
   localparam logic [7:0] PERIOD_TOP  = 8'd140;
   localparam int         PERIOD_ROM_SIZE = 104;
   localparam int         DRUM_ROM_SIZE   = 20;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  voice;
      logic [7:0]  data_a;   // pulse volume byte or drum envelope
      logic [7:0]  data_b;   // drum NR43
      logic [10:0] period;
   } cmd_type;

   localparam logic [10:0] PERIOD_ROM [0:PERIOD_ROM_SIZE-1] = '{
      11'd44,   11'd157,  11'd263,  11'd363,  11'd457,  11'd547,  11'd631,  11'd711,
      11'd786,  11'd856,  11'd923,  11'd986,  11'd1046, 11'd1102, 11'd1155, 11'd1205,
      11'd1253, 11'd1297, 11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
      11'd1547, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673, 11'd1694, 11'd1714,
      11'd1732, 11'd1750, 11'd1767, 11'd1783, 11'd1798, 11'd1812, 11'd1825, 11'd1837,
      11'd1849, 11'd1860, 11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
      11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954, 11'd1959, 11'd1964,
      11'd1969, 11'd1974, 11'd1978, 11'd1982, 11'd1985, 11'd1989, 11'd1992, 11'd1995,
      11'd1998, 11'd2001, 11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015,
      11'd2017, 11'd2018, 11'd2020, 11'd2022, 11'd2023, 11'd2025, 11'd2026, 11'd2027,
      11'd2028, 11'd2029, 11'd2030, 11'd2031, 11'd2032, 11'd2033, 11'd2034, 11'd2035,
      11'd2036, 11'd2036, 11'd2037, 11'd2038, 11'd2038, 11'd2039, 11'd2039, 11'd2040,
      11'd2040, 11'd2041, 11'd2041, 11'd2041, 11'd2042, 11'd2042, 11'd2042, 11'd2043
   };

   // drum presets; entry 0 doubles as the fallback for unknown ids
   localparam logic [7:0] DRUM_ENV [0:DRUM_ROM_SIZE-1] = '{
      8'h81, 8'hC1, 8'hB1, 8'hA1, 8'h81, 8'h84, 8'h51, 8'h41, 8'h81, 8'h82,
      8'h82, 8'h82, 8'hA1, 8'hA2, 8'hA2, 8'hA1, 8'h91, 8'h91, 8'h71, 8'h61
   };
   localparam logic [7:0] DRUM_NR43 [0:DRUM_ROM_SIZE-1] = '{
      8'h22, 8'h33, 8'h33, 8'h33, 8'h33, 8'h37, 8'h2A, 8'h2B, 8'h10, 8'h23,
      8'h25, 8'h26, 8'h10, 8'h11, 8'h50, 8'h18, 8'h28, 8'h22, 8'h22, 8'h22
   };

   function automatic logic [10:0] period_of(input logic [7:0] pitch);
      logic [7:0] diff;
      logic [6:0] offs;
      diff = pitch - PERIOD_BASE;
      offs = diff[6:0];
      if (pitch < PERIOD_BASE) begin
         return 11'd0;
      end else if (pitch >= PERIOD_TOP) begin
         return 11'd2047;
      end
      return PERIOD_ROM[offs];
   endfunction

   // velocity * 15 / 127, floored and clamped to 1..15
   function automatic logic [3:0] volume_of(input logic [6:0] vel);
      logic [10:0] scaled;
      logic [3:0]  vol;
      scaled = 11'(vel) * 11'd15;
      vol = 4'd1;
      for (int k = 1; k <= 15; k++) begin
         if (scaled >= 11'(127 * k)) vol = 4'(k);
      end
      return vol;
   endfunction

endpackage

// ----- sv/m2p_if.sv -----
// Channel interfaces: MIDI event requests, register write responses, enable register.
// Depends on nothing.
interface m2p_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] event_kind;
   logic [3:0] midi_channel;
   logic [6:0] note_number;
   logic [6:0] velocity;
   logic [1:0] byte_count;

   modport source (output valid, event_kind, midi_channel, note_number, velocity,
                   byte_count, input ready);
   modport sink   (input valid, event_kind, midi_channel, note_number, velocity,
                   byte_count, output ready);
endinterface

interface m2p_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] reg_address;
   logic [7:0]  reg_data;
   logic        last_write;

   modport source (output valid, reg_address, reg_data, last_write, input ready);
   modport sink   (input valid, reg_address, reg_data, last_write, output ready);
endinterface

interface m2p_csr_if;
   logic valid;
   logic ready;
   logic engine_enable;

   modport source (output valid, engine_enable, input ready);
   modport sink   (input valid, engine_enable, output ready);
endinterface

// ----- sv/m2p_front.sv -----
// Front end: holds the enable register, classifies each MIDI event and builds a command.
// Depends on m2p_pkg and the channel interfaces.
module m2p_front (
   input  logic            clock,
   input  logic            reset,
   m2p_req_if.sink         req_ch,
   m2p_csr_if.sink         csr_ch,
   input  logic            queue_full,
   output logic            push,
   output m2p_pkg::cmd_type cmd
);

   logic       enable_ff, enable_in;
   logic       mapped;
   logic [1:0] voice;
   logic       is_on;
   logic       keep;
   logic [7:0] pitch;
   logic [4:0] drum_id;
   logic [3:0] vol;

   assign csr_ch.ready = 1'b1;
   assign enable_in = (csr_ch.valid) ? csr_ch.engine_enable : enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // dropped events are still taken, they just never reach the queue
   assign req_ch.ready = !queue_full;

   always_comb begin
      mapped = 1'b1;
      voice  = m2p_pkg::VOICE_PULSE1;
      if (req_ch.midi_channel == 4'd9) begin
         voice = m2p_pkg::VOICE_NOISE;
      end else if (req_ch.midi_channel == 4'd3) begin
         voice = m2p_pkg::VOICE_WAVE;
      end else if (req_ch.midi_channel == 4'd2) begin
         voice = m2p_pkg::VOICE_PULSE2;
      end else if (req_ch.midi_channel > 4'd1) begin
         mapped = 1'b0;
      end
   end

   assign is_on = (req_ch.event_kind == m2p_pkg::NOTE_ON) && (req_ch.byte_count == 2'd3);
   assign keep  = enable_ff && (req_ch.byte_count != 2'd0) && mapped &&
                  (is_on || (req_ch.event_kind == m2p_pkg::NOTE_OFF));
   assign push  = req_ch.valid && req_ch.ready && keep;

   // wave voice plays one octave up on the same curve
   assign pitch   = {1'b0, req_ch.note_number} + ((voice == m2p_pkg::VOICE_WAVE) ? 8'd12 : 8'd0);
   assign drum_id = (req_ch.note_number <= 7'd19) ? req_ch.note_number[4:0] : 5'd0;
   assign vol     = m2p_pkg::volume_of(req_ch.velocity);

   always_comb begin
      cmd.voice  = voice;
      cmd.period = m2p_pkg::period_of(pitch);
      cmd.data_a = {vol, 4'h0};
      cmd.data_b = 8'h00;
      if (!is_on || (req_ch.velocity == 7'd0)) begin
         cmd.op = m2p_pkg::OP_OFF;
      end else begin
         case (voice)
            m2p_pkg::VOICE_WAVE: begin
               cmd.op = m2p_pkg::OP_WAVE_ON;
            end
            m2p_pkg::VOICE_NOISE: begin
               cmd.op     = m2p_pkg::OP_NOISE_ON;
               cmd.data_a = m2p_pkg::DRUM_ENV[drum_id];
               cmd.data_b = m2p_pkg::DRUM_NR43[drum_id];
            end
            default: begin
               cmd.op = m2p_pkg::OP_PULSE_ON;
            end
         endcase
      end
   end

endmodule

// ----- sv/m2p_cmd_fifo.sv -----
// Short command queue between the front end and the write sequencer.
// Depends on m2p_pkg.
module m2p_cmd_fifo #(
   parameter int DEPTH = m2p_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  m2p_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output m2p_pkg::cmd_type head_cmd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   m2p_pkg::cmd_type entry_ff [0:DEPTH-1];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- sv/m2p_back.sv -----
// Write sequencer: steps through the register writes of the command at the queue head.
// Depends on m2p_pkg and the response interface.
module m2p_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  m2p_pkg::cmd_type head_cmd,
   output logic             pop,
   m2p_rsp_if.source        rsp_ch
);

   localparam logic [15:0] ADDR_PULSE1 = 16'hFF11;
   localparam logic [15:0] ADDR_PULSE2 = 16'hFF16;
   localparam logic [15:0] ADDR_WAVE   = 16'hFF1A;
   localparam logic [15:0] ADDR_NOISE  = 16'hFF21;
   localparam logic [15:0] ADDR_NOISE_TRIG = 16'hFF23;
   localparam logic [15:0] ADDR_PULSE1_ENV = 16'hFF12;
   localparam logic [15:0] ADDR_PULSE2_ENV = 16'hFF17;
   localparam logic [15:0] ADDR_WAVE_LEVEL = 16'hFF1C;

   logic        valid_ff, valid_in;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;
   logic        last_ff;
   logic [2:0]  step_ff, step_in;

   logic        load;
   logic [15:0] base;
   logic [15:0] addr;
   logic [7:0]  data;
   logic [2:0]  count;
   logic        last;
   logic [7:0]  period_hi;

   assign period_hi = {5'b10000, head_cmd.period[10:8]};

   always_comb begin
      base  = ADDR_PULSE1;
      data  = 8'h00;
      count = 3'd1;
      case (head_cmd.op)
         m2p_pkg::OP_PULSE_ON: begin
            base  = (head_cmd.voice == m2p_pkg::VOICE_PULSE1) ? ADDR_PULSE1 : ADDR_PULSE2;
            count = 3'd4;
            case (step_ff)
               3'd0:    data = 8'h80;
               3'd1:    data = head_cmd.data_a;
               3'd2:    data = head_cmd.period[7:0];
               default: data = period_hi;
            endcase
         end
         m2p_pkg::OP_WAVE_ON: begin
            base  = ADDR_WAVE;
            count = 3'd5;
            case (step_ff)
               3'd0:    data = 8'h80;
               3'd1:    data = 8'hFF;
               3'd2:    data = 8'h20;
               3'd3:    data = head_cmd.period[7:0];
               default: data = period_hi;
            endcase
         end
         m2p_pkg::OP_NOISE_ON: begin
            base  = ADDR_NOISE;
            count = 3'd3;
            case (step_ff)
               3'd0:    data = head_cmd.data_a;
               3'd1:    data = head_cmd.data_b;
               default: data = 8'h80;
            endcase
         end
         default: begin
            // silence: one envelope write, noise also retriggers
            case (head_cmd.voice)
               m2p_pkg::VOICE_PULSE1: base = ADDR_PULSE1_ENV;
               m2p_pkg::VOICE_PULSE2: base = ADDR_PULSE2_ENV;
               m2p_pkg::VOICE_WAVE:   base = ADDR_WAVE_LEVEL;
               default: begin
                  base  = ADDR_NOISE;
                  count = 3'd2;
               end
            endcase
            data = (step_ff == 3'd0) ? 8'h00 : 8'h80;
         end
      endcase
   end

   // the noise silence pair skips straight from the envelope to the trigger register
   assign addr = (head_cmd.op == m2p_pkg::OP_OFF && step_ff != 3'd0) ? ADDR_NOISE_TRIG
                                                                      : base + 16'(step_ff);
   assign last = (step_ff == count - 3'd1);
   assign load = head_valid && (!valid_ff || rsp_ch.ready);
   assign pop  = load && last;

   assign step_in  = load ? (last ? 3'd0 : step_ff + 3'd1) : step_ff;
   assign valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff <= addr;
         data_ff <= data;
         last_ff <= last;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.reg_address = addr_ff;
   assign rsp_ch.reg_data    = data_ff;
   assign rsp_ch.last_write  = last_ff;

endmodule

// ----- sv/midi_event_to_psg_register_writes.sv -----
// Top level: MIDI event in, ordered sound register writes out.
// Depends on m2p_pkg, the channel interfaces, m2p_front, m2p_cmd_fifo and m2p_back.
//
//   channel   role    beat carries
//   req_ch    sink    one MIDI event (kind, channel, note, velocity, byte count)
//   rsp_ch    source  one register write (address, data, last flag)
//   csr_ch    sink    engine enable bit
//
// The front end takes one event per cycle while the command queue has room.
// The sequencer gives one write per cycle while a command waits and rsp_ch is ready;
// an event needs 1 to 5 writes, and dropped events never enter the queue.
// Back-pressure on rsp_ch stalls the sequencer alone until the queue fills.
// Reset clears the enable bit, the queue and the output valid flag.
module midi_event_to_psg_register_writes #(
   parameter int QUEUE_DEPTH = m2p_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   m2p_req_if.sink   req_ch,
   m2p_rsp_if.source rsp_ch,
   m2p_csr_if.sink   csr_ch
);

   logic             queue_full;
   logic             push;
   logic             pop;
   logic             head_valid;
   m2p_pkg::cmd_type push_cmd;
   m2p_pkg::cmd_type head_cmd;

   m2p_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   m2p_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   m2p_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ----- sv/m2p_checker.sv -----
// Port-level checks on the register write channel, bound to the top level.
// Depends on the assertion macros header.
`include "midi_event_to_psg_register_writes_macros.svh"

module m2p_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_reg_address,
   input logic [7:0]  rsp_reg_data,
   input logic        rsp_last_write
);

   `M2P_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "write beat right after reset")

   `M2P_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reg_address) && $stable(rsp_reg_data) && $stable(rsp_last_write), "stalled write beat changed")

   `M2P_ASSERT(a_addr_range, clock, reset, rsp_valid |-> rsp_reg_address >= 16'hFF11 && rsp_reg_address <= 16'hFF23, "write outside sound registers")

   // trigger registers always close an event
   `M2P_ASSERT(a_trigger_last, clock, reset, rsp_valid && (rsp_reg_address == 16'hFF14 || rsp_reg_address == 16'hFF19 || rsp_reg_address == 16'hFF1E || rsp_reg_address == 16'hFF23) |-> rsp_last_write, "trigger write not flagged last")

endmodule

bind midi_event_to_psg_register_writes m2p_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_reg_address (rsp_ch.reg_address),
   .rsp_reg_data    (rsp_ch.reg_data),
   .rsp_last_write  (rsp_ch.last_write)
);
